FILE: src/shortest_seek_first_distance_top_macros.svh
// Assertion macros for the checker of this block.
`ifndef SHORTEST_SEEK_FIRST_DISTANCE_TOP_MACROS_SVH
`define SHORTEST_SEEK_FIRST_DISTANCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SSFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, sampled on clock, off during reset.
`define SSFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: src/ssfd_pkg.sv
package ssfd_pkg;

   localparam int MAX_REQUESTS = 64;
   localparam int TOP_CYLINDER = 999;

   localparam int CYL_W    = 10;
   localparam int TRAVEL_W = 16;
   localparam int IDX_W    = $clog2(MAX_REQUESTS);
   localparam int CNT_W    = $clog2(MAX_REQUESTS + 1);

   localparam logic [CYL_W-1:0]    TOP_CYL          = CYL_W'(TOP_CYLINDER);
   localparam logic [CYL_W-1:0]    START_HEAD_RESET = CYL_W'(50);
   localparam logic [TRAVEL_W-1:0] TRAVEL_MAX       = '1;

   // Running nearest-candidate word handed from cell to cell.
   typedef struct packed {
      logic             found;
      logic [CYL_W-1:0] seek;
      logic [CYL_W-1:0] cyl;
      logic [IDX_W-1:0] idx;
   } token_type;

   localparam token_type TOKEN_IDLE = '0;

   // Broadcast from the scheduler to every cell.
   typedef struct packed {
      logic             shift;
      logic             clear;
      logic             serve;
      logic [IDX_W-1:0] serve_idx;
      logic [CYL_W-1:0] head;
   } cell_ctrl_type;

   function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] c);
      return (c > TOP_CYL) ? TOP_CYL : c;
   endfunction

endpackage

FILE: src/ssfd_cell.sv
module ssfd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  ssfd_pkg::cell_ctrl_type      ctrl,
   input  logic [ssfd_pkg::IDX_W-1:0]   cell_idx,
   input  logic                         vld_in,
   input  logic [ssfd_pkg::CYL_W-1:0]   cyl_in,
   output logic                         vld_out,
   output logic [ssfd_pkg::CYL_W-1:0]   cyl_out,
   input  ssfd_pkg::token_type          tok_in,
   output ssfd_pkg::token_type          tok_out
);
   import ssfd_pkg::*;

   logic             valid_ff, valid_in;
   logic             served_ff, served_in;
   logic [CYL_W-1:0] cyl_ff, cyl_next_in;
   token_type        tok_ff, tok_next_in;
   logic [CYL_W-1:0] seek_len;
   logic             take_own;

   // Distance from the head; an unserved entry replaces the incoming
   // candidate only when strictly nearer, so older entries win ties.
   always_comb begin
      seek_len = (cyl_ff >= ctrl.head) ? (cyl_ff - ctrl.head) : (ctrl.head - cyl_ff);
      take_own = valid_ff && !served_ff && (!tok_in.found || (seek_len < tok_in.seek));
      if (take_own) begin
         tok_next_in = '{found: 1'b1, seek: seek_len, cyl: cyl_ff, idx: cell_idx};
      end else begin
         tok_next_in = tok_in;
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      served_in   = served_ff;
      cyl_next_in = cyl_ff;
      if (ctrl.clear) begin
         valid_in  = 1'b0;
         served_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in    = vld_in;
         served_in   = 1'b0;
         cyl_next_in = cyl_in;
      end else if (ctrl.serve && (ctrl.serve_idx == cell_idx)) begin
         served_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         served_ff <= 1'b0;
         tok_ff    <= TOKEN_IDLE;
      end else begin
         valid_ff  <= valid_in;
         served_ff <= served_in;
         tok_ff    <= tok_next_in;
      end
      cyl_ff <= cyl_next_in;
   end

   assign vld_out = valid_ff;
   assign cyl_out = cyl_ff;
   assign tok_out = tok_ff;

endmodule

FILE: src/ssfd_sched.sv
module ssfd_sched (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ssfd_pkg::CYL_W-1:0]      req_cylinder,
   input  logic                            req_last_request,
   input  logic [ssfd_pkg::CYL_W-1:0]      start_head,
   input  ssfd_pkg::token_type             tok,
   output ssfd_pkg::cell_ctrl_type         ctrl,
   output logic [ssfd_pkg::CYL_W-1:0]      load_cyl,
   output logic                            rsp_valid,
   output logic [ssfd_pkg::TRAVEL_W-1:0]   rsp_total_travel,
   output logic                            rsp_dropped
);
   import ssfd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } sched_state_type;

   sched_state_type     state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    sweep_ff, sweep_in;
   logic [CYL_W-1:0]    head_ff, head_in;
   logic [TRAVEL_W-1:0] travel_ff, travel_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TRAVEL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   logic                accept, store_full, sweep_done, emit;
   logic [TRAVEL_W:0]   sum_wide;

   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      store_full = (count_ff == CNT_W'(MAX_REQUESTS));
      sweep_done = (state_ff == ST_SWEEP) && (sweep_ff == CNT_W'(MAX_REQUESTS));
      emit       = sweep_done && !tok.found;
      sum_wide   = (TRAVEL_W+1)'(travel_ff) + (TRAVEL_W+1)'(tok.seek);
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      sweep_in       = sweep_ff;
      head_in        = head_ff;
      travel_in      = travel_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = 1'b0;
      rsp_total_in   = rsp_total_ff;
      rsp_dropped_in = rsp_dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_request) begin
                  state_in  = ST_SWEEP;
                  sweep_in  = '0;
                  head_in   = clamp_cyl(start_head);
                  travel_in = '0;
               end
            end
         end
         ST_SWEEP: begin
            if (!sweep_done) begin
               sweep_in = sweep_ff + CNT_W'(1);
            end else if (tok.found) begin
               sweep_in  = '0;
               head_in   = tok.cyl;
               travel_in = sum_wide[TRAVEL_W] ? TRAVEL_MAX : sum_wide[TRAVEL_W-1:0];
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_total_in   = travel_ff;
               rsp_dropped_in = overflow_ff;
               count_in       = '0;
               overflow_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sweep_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= START_HEAD_RESET;
         travel_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         travel_ff    <= travel_in;
      end
      rsp_total_ff   <= rsp_total_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_comb begin
      ctrl.shift     = accept && !store_full;
      ctrl.clear     = emit;
      ctrl.serve     = sweep_done && tok.found;
      ctrl.serve_idx = tok.idx;
      ctrl.head      = head_ff;
   end

   assign load_cyl         = clamp_cyl(req_cylinder);
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_travel = rsp_total_ff;
   assign rsp_dropped      = rsp_dropped_ff;

endmodule

FILE: src/shortest_seek_first_distance_top.sv
// Shortest-seek-first arm scheduler. Drive start with a request word
// (req_cylinder, req_last_request); it is taken on any clock edge with
// start high and busy low, one word per cycle while loading. A word with
// req_last_request set closes the set and starts scheduling from the
// cylinder held in the start-head register (csr_wdata, written when
// csr_we is high; write it only while busy is low). Scheduling runs a
// round per stored request: each round passes a nearest-candidate word
// down the full row of MAX_REQUESTS cells, one cell per cycle, and one
// extra round finds nothing left. busy stays high while it runs. The
// single result (total travel, saturated at 65535, and the dropped
// flag for words beyond the MAX_REQUESTS-entry store) shows on rsp_*
// for exactly one cycle with rsp_valid high. There is no backpressure:
// capture it in that cycle.
// A new set may start in the same cycle the result is shown.
module shortest_seek_first_distance_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ssfd_pkg::CYL_W-1:0]      req_cylinder,
   input  logic                            req_last_request,
   output logic                            rsp_valid,
   output logic [ssfd_pkg::TRAVEL_W-1:0]   rsp_total_travel,
   output logic                            rsp_dropped,
   input  logic                            csr_we,
   input  logic [ssfd_pkg::CYL_W-1:0]      csr_wdata
);
   import ssfd_pkg::*;

   // Start-head register; clamped where it is used.
   logic [CYL_W-1:0] start_head_ff, start_head_in;

   cell_ctrl_type    ctrl;
   logic [CYL_W-1:0] load_cyl;

   // Load path runs toward higher cells (oldest request sits deepest);
   // the candidate word runs back toward cell 0.
   logic [MAX_REQUESTS-1:0] vld_chain;
   logic [CYL_W-1:0]        cyl_chain [MAX_REQUESTS];
   token_type               tok_chain [MAX_REQUESTS];

   assign start_head_in = csr_we ? csr_wdata : start_head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= START_HEAD_RESET;
      end else begin
         start_head_ff <= start_head_in;
      end
   end

   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      logic             vld_feed;
      logic [CYL_W-1:0] cyl_feed;
      token_type        tok_feed;

      // Cell 0 takes the fresh word; the last cell sees an empty candidate.
      if (i == 0) begin : g_head
         assign vld_feed = 1'b1;
         assign cyl_feed = load_cyl;
      end else begin : g_body
         assign vld_feed = vld_chain[i-1];
         assign cyl_feed = cyl_chain[i-1];
      end

      if (i == MAX_REQUESTS - 1) begin : g_tail
         assign tok_feed = TOKEN_IDLE;
      end else begin : g_pass
         assign tok_feed = tok_chain[i+1];
      end

      ssfd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .cell_idx (IDX_W'(i)),
         .vld_in   (vld_feed),
         .cyl_in   (cyl_feed),
         .vld_out  (vld_chain[i]),
         .cyl_out  (cyl_chain[i]),
         .tok_in   (tok_feed),
         .tok_out  (tok_chain[i])
      );
   end

   // Hold the head, count loads and rounds, sum the travel, drive the row.
   ssfd_sched u_sched (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cylinder     (req_cylinder),
      .req_last_request (req_last_request),
      .start_head       (start_head_ff),
      .tok              (tok_chain[0]),
      .ctrl             (ctrl),
      .load_cyl         (load_cyl),
      .rsp_valid        (rsp_valid),
      .rsp_total_travel (rsp_total_travel),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

FILE: src/ssfd_checker.sv
`include "shortest_seek_first_distance_top_macros.svh"

module ssfd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_request,
   input logic rsp_valid
);

   logic mid_set_word;

   assign mid_set_word = start && !busy && !req_last_request;

   // A result only closes a scheduling pass.
   `SSFD_ASSERT_NOW(a_rsp_after_busy, rsp_valid, $past(busy))
   // The block is back to idle when it shows the result.
   `SSFD_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)
   // Results never come on consecutive cycles.
   `SSFD_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // A word that does not close the set leaves the block ready.
   `SSFD_ASSERT_NEXT(a_load_no_busy, mid_set_word, !busy && !rsp_valid)

endmodule

bind shortest_seek_first_distance_top ssfd_checker u_ssfd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_last_request (req_last_request),
   .rsp_valid        (rsp_valid)
);

FILE: tb/sv/tb_shortest_seek_first_distance_top.sv
module tb_shortest_seek_first_distance_top;
   import ssfd_pkg::*;

   // Pause after the last result before touching the start-head register:
   // covers the empty closing round of a full row plus margin.
   localparam int SETTLE_CYCLES = 2 * (MAX_REQUESTS + 1);
   // Guard time: the slowest legal run stays far below this.
   localparam int RUN_LIMIT = 20_000_000;

   // One request word as the sender presents it.
   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic             last_request;
   } seek_word_type;

   // One travel word as the block reports it.
   typedef struct packed {
      logic [TRAVEL_W-1:0] travel;
      logic                dropped;
   } travel_word_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [CYL_W-1:0]    req_cylinder     = '0;
   logic                req_last_request = 1'b0;
   logic                rsp_valid;
   logic [TRAVEL_W-1:0] rsp_total_travel;
   logic                rsp_dropped;
   logic                csr_we           = 1'b0;
   logic [CYL_W-1:0]    csr_wdata        = '0;

   // Words waiting to go out, and travel words owed by the block.
   seek_word_type   pending_words[$];
   travel_word_type travel_due[$];

   // Shadow of the block's request set and start-head register.
   logic [CYL_W-1:0] cyl_store [MAX_REQUESTS];
   int               cyl_count = 0;
   bit               drop_seen = 1'b0;
   logic [CYL_W-1:0] head_cfg  = START_HEAD_RESET;

   // Percentage of cycles in which the sender holds off.
   int idle_pct = 0;

   int error_count   = 0;
   int words_taken   = 0;
   int sets_closed   = 0;
   int sets_dropped  = 0;
   int results_seen  = 0;
   int head_settings = 1;

   always #5 clock = ~clock;

   shortest_seek_first_distance_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cylinder     (req_cylinder),
      .req_last_request (req_last_request),
      .rsp_valid        (rsp_valid),
      .rsp_total_travel (rsp_total_travel),
      .rsp_dropped      (rsp_dropped),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Serve the shadow set nearest-first from the start head and sum the travel.
   // Ties go to the lowest store slot, i.e. the earliest loaded request.
   function automatic travel_word_type close_set();
      bit              served [MAX_REQUESTS];
      int              head;
      int              pick;
      int              best;
      int              seek_len;
      int              sum;
      travel_word_type res;
      foreach (served[i]) served[i] = 1'b0;
      head = (head_cfg > TOP_CYL) ? TOP_CYLINDER : int'(head_cfg);
      sum  = 0;
      for (int round = 0; round < cyl_count; round++) begin
         pick = -1;
         best = 0;
         for (int i = 0; i < cyl_count; i++) begin
            if (!served[i]) begin
               seek_len = head - int'(cyl_store[i]);
               if (seek_len < 0) seek_len = -seek_len;
               if (pick < 0 || seek_len < best) begin
                  pick = i;
                  best = seek_len;
               end
            end
         end
         sum = sum + best;
         if (sum > int'(TRAVEL_MAX)) sum = int'(TRAVEL_MAX);
         head = int'(cyl_store[pick]);
         served[pick] = 1'b1;
      end
      res.travel  = TRAVEL_W'(sum);
      res.dropped = drop_seen;
      return res;
   endfunction

   // Driver: retire the word taken at this edge into the shadow set, then
   // present the next one, hold the current one while busy, or idle.
   always @(posedge clock) begin : drive_words
      logic [CYL_W-1:0] cyl;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            void'(pending_words.pop_front());
            words_taken++;
            // Saturate out-of-range cylinders at the top cylinder.
            cyl = (req_cylinder > TOP_CYL) ? TOP_CYL : req_cylinder;
            if (cyl_count < MAX_REQUESTS) begin
               cyl_store[cyl_count] = cyl;
               cyl_count++;
            end else begin
               // Store full: drop the word, flag the set.
               drop_seen = 1'b1;
            end
            if (req_last_request) begin
               travel_due.push_back(close_set());
               sets_closed++;
               if (drop_seen) sets_dropped++;
               cyl_count = 0;
               drop_seen = 1'b0;
            end
         end
         if (start && busy) begin
            // Hold the offered word until the block takes it.
         end else if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start            <= 1'b1;
            req_cylinder     <= pending_words[0].cylinder;
            req_last_request <= pending_words[0].last_request;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobed travel word must match the oldest one owed.
   always @(posedge clock) begin : check_travel
      travel_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (travel_due.size() == 0) begin
            report_error($sformatf("unexpected result: travel %0d dropped %0b",
                                   rsp_total_travel, rsp_dropped));
         end else begin
            want = travel_due.pop_front();
            if (rsp_total_travel !== want.travel)
               report_error($sformatf("total_travel %0d, expected %0d",
                                      rsp_total_travel, want.travel));
            if (rsp_dropped !== want.dropped)
               report_error($sformatf("dropped %0b, expected %0b",
                                      rsp_dropped, want.dropped));
         end
      end
   end

   task automatic queue_word(input int cyl, input bit last);
      seek_word_type w;
      w.cylinder     = CYL_W'(cyl);
      w.last_request = last;
      pending_words.push_back(w);
   endtask

   // Queue one set of n words, the final one marked last. Cluster some words
   // around an anchor to provoke equal seeks and repeated cylinders.
   task automatic queue_set(input int n);
      int anchor;
      int cyl;
      anchor = $urandom_range(0, 1023);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               cyl = $urandom_range(TOP_CYLINDER + 1, 1023);
            end
            1, 2: begin
               cyl = anchor + $urandom_range(0, 8) - 4;
               if (cyl < 0) cyl = 0;
               if (cyl > 1023) cyl = 1023;
            end
            default: begin
               cyl = $urandom_range(0, 1023);
            end
         endcase
         queue_word(cyl, i == n - 1);
      end
   endtask

   // Let every queued word go in and every owed result come out, then let
   // the block finish its closing round before anything else happens.
   task automatic drain();
      while (pending_words.size() != 0 || travel_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_head(input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CYL_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      head_cfg   = CYL_W'(value);
      head_settings++;
   endtask

   initial begin : stimulus
      int sender_idle [3];
      int phase_words;
      int n;
      sender_idle = '{18, 74, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed sets from the reset start head (50).
      idle_pct = sender_idle[0];
      queue_word(0, 1'b1);                   // lowest cylinder alone
      queue_word(TOP_CYLINDER, 1'b1);        // top cylinder alone
      queue_word(1023, 1'b1);                // above range, saturates
      queue_word(60, 1'b0);                  // equal seek from 50: earliest wins
      queue_word(40, 1'b0);
      queue_word(100, 1'b1);
      queue_word(50, 1'b0);                  // all on the head: zero travel
      queue_word(50, 1'b0);
      queue_word(50, 1'b1);
      queue_word(0, 1'b0);                   // sweep to both ends
      queue_word(TOP_CYLINDER, 1'b0);
      queue_word(1, 1'b1);
      drain();

      // Lowest start head.
      write_head(0);
      queue_word(1023, 1'b1);
      queue_word(512, 1'b0);
      queue_word(256, 1'b0);
      queue_word(1, 1'b1);
      drain();

      // Start head above range: saturates to the top cylinder.
      write_head(1023);
      queue_word(0, 1'b1);
      queue_word(TOP_CYLINDER + 1, 1'b0);
      queue_word(TOP_CYLINDER - 1, 1'b1);
      drain();

      // Random phases, two per sender idle level. Every other phase opens
      // with a set that fills the store, then one that spills the last
      // word, then one that spills several.
      for (int p = 0; p < 6; p++) begin
         idle_pct = sender_idle[p / 2];
         case (p)
            3:       write_head(0);
            5:       write_head(TOP_CYLINDER);
            default: write_head($urandom_range(0, 1023));
         endcase
         phase_words = 0;
         if (p % 2 == 0) begin
            case (p)
               0:       n = MAX_REQUESTS;
               2:       n = MAX_REQUESTS + 1;
               default: n = MAX_REQUESTS + $urandom_range(2, 8);
            endcase
            queue_set(n);
            phase_words += n;
         end
         while (phase_words < 75) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 12);
            queue_set(n);
            phase_words += n;
         end
         drain();
      end

      $display("Covered %0d request words in %0d sets (%0d with dropped words) over %0d start heads",
               words_taken, sets_closed, sets_dropped, head_settings);
      $display("Sender idle at 18, 74 and 0 percent; %0d travel words checked", results_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #RUN_LIMIT;
      $display("Timeout: run did not finish in time");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
